### hdl/ssw_pkg.sv
// Shared types, codes and helpers for the string slot table with write-back.
package ssw_pkg;

  localparam int CHARS = 14;

  typedef logic [CHARS-1:0][7:0] text_t;

  localparam logic [2:0] OP_UPDATE    = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_BUS_DONE  = 3'd2;
  localparam logic [2:0] OP_ADD       = 3'd3;
  localparam logic [2:0] OP_DELETE    = 3'd4;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_STARTED   = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] CFG_WRITE_CYCLE_MS = 2'd0;
  localparam logic [1:0] CFG_TABLE_BASE     = 2'd1;

  localparam logic [7:0]  WRITE_CYCLE_MS_RESET = 8'd5;
  localparam logic [15:0] TABLE_BASE_RESET     = 16'd16;

  typedef struct packed {
    logic       clr_wr;
    logic       scan_rst;
    logic       rd_scan;
    logic       rd_active;
    logic       hit_wr;
    logic       latch;
    logic       start_wb;
    logic       byte_inc;
    logic       bus_clr;
    logic       bus_set;
    logic       ms_tick;
    logic       ms_clr;
    logic       out_load;
    logic       out_wv;
    logic       out_busy;
    logic [1:0] out_st;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       chk_last;
    logic       scan_last;
    logic       elapsed_ge;
    logic       bus_flag;
    logic       is_delete;
    logic       byte_done;
    logic       byte_zero;
    logic       out_free;
  } ctrl_stat_t;

  function automatic text_t normalize(input logic [55:0] lo, input logic [55:0] hi);
    text_t      t;
    logic       ended;
    logic [7:0] c;
    ended = 1'b0;
    for (int i = 0; i < CHARS; i++) begin
      c = (i < 7) ? lo[8*i +: 8] : hi[8*(i-7) +: 8];
      if (c == 8'd0) ended = 1'b1;
      t[i] = ended ? 8'd0 : c;
    end
    return t;
  endfunction

endpackage

### hdl/ssw_in_if.sv
// Input channel: command op and string text with valid/ready.
interface ssw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [55:0] text_low;
  logic [55:0] text_high;

  modport source (output valid, op, text_low, text_high, input ready);
  modport sink   (input valid, op, text_low, text_high, output ready);
endinterface

### hdl/ssw_out_if.sv
// Result channel: byte write command, busy, status and slot with valid/ready.
interface ssw_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic        busy_res;
  logic [1:0]  status;
  logic [7:0]  slot;

  modport source (output valid, write_valid, write_address, write_data, busy_res, status,
                  slot, input ready);
  modport sink   (input valid, write_valid, write_address, write_data, busy_res, status,
                  slot, output ready);
endinterface

### hdl/string_slot_table_eeprom_writeback.sv
// Top level: string slot table with byte-wise write-back to external memory.
// One item at a time. Update, tick and bus-done items skip the scan; the result loads once the output is free.
// Add and delete scan the slot memory one slot per cycle, stopping at the first hit or the last slot.
// The next item is accepted the cycle after its predecessor's result is loaded.
// After reset a clearing pass zeroes every slot of the table; items wait, config is taken.
module string_slot_table_eeprom_writeback #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ssw_in_if.sink      in_ch,
  ssw_out_if.source   out_ch
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ssw_pkg::ctrl_cmd_t  cmd;
  ssw_pkg::ctrl_stat_t stat;

  ssw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssw_dp #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_ch.op),
    .in_text_low   (in_ch.text_low),
    .in_text_high  (in_ch.text_high),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .write_valid   (out_ch.write_valid),
    .write_address (out_ch.write_address),
    .write_data    (out_ch.write_data),
    .busy_res      (out_ch.busy_res),
    .status        (out_ch.status),
    .slot          (out_ch.slot)
  );

endmodule

### hdl/ssw_dp.sv
// Datapath: slot memory, config registers, write-back registers and result register.
module ssw_dp #(
  parameter int SLOTS  = 256,
  parameter int SLOT_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [2:0]           in_op,
  input  logic [55:0]          in_text_low,
  input  logic [55:0]          in_text_high,
  input  ssw_pkg::ctrl_cmd_t   cmd,
  output ssw_pkg::ctrl_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 write_valid,
  output logic [15:0]          write_address,
  output logic [7:0]           write_data,
  output logic                 busy_res,
  output logic [1:0]           status,
  output logic [7:0]           slot
);

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  ssw_pkg::text_t    mem [SLOTS];
  ssw_pkg::text_t    rd_data;
  ssw_pkg::text_t    txt;
  ssw_pkg::text_t    wr_data;
  logic [2:0]        op;
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] chk_addr;
  logic [SLOT_W-1:0] active_slot;
  logic [SLOT_W-1:0] wr_addr;
  logic              wr_en;
  logic [3:0]        byte_index;
  logic              is_delete;
  logic              bus_flag;
  logic [7:0]        elapsed_ms;
  logic [7:0]        write_cycle_ms;
  logic [15:0]       table_base_address;
  logic [7:0]        cur_byte;
  logic [15:0]       slot_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cycle_ms     <= ssw_pkg::WRITE_CYCLE_MS_RESET;
      table_base_address <= ssw_pkg::TABLE_BASE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ssw_pkg::CFG_WRITE_CYCLE_MS: write_cycle_ms     <= cfg_data[7:0];
        ssw_pkg::CFG_TABLE_BASE:     table_base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= in_op;
      txt <= ssw_pkg::normalize(in_text_low, in_text_high);
    end
  end

  assign wr_en   = cmd.clr_wr | cmd.hit_wr;
  assign wr_addr = cmd.clr_wr ? scan_addr : chk_addr;
  assign wr_data = (cmd.clr_wr || op == ssw_pkg::OP_DELETE) ? '0 : txt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_scan) begin
      rd_data <= mem[scan_addr];
    end else if (cmd.rd_active) begin
      rd_data <= mem[active_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (cmd.scan_rst) begin
      scan_addr <= '0;
    end else if (cmd.clr_wr || cmd.rd_scan) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_scan) begin
      chk_addr <= scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slot <= '0;
      byte_index  <= '0;
      is_delete   <= 1'b0;
      bus_flag    <= 1'b0;
      elapsed_ms  <= '0;
    end else begin
      if (cmd.start_wb) begin
        active_slot <= chk_addr;
        byte_index  <= '0;
        is_delete   <= (op == ssw_pkg::OP_DELETE) || (txt[0] == 8'd0);
      end else if (cmd.byte_inc) begin
        byte_index <= byte_index + 4'd1;
      end
      if (cmd.bus_clr) begin
        bus_flag <= 1'b0;
      end else if (cmd.bus_set) begin
        bus_flag <= 1'b1;
      end
      if (cmd.ms_clr) begin
        elapsed_ms <= '0;
      end else if (cmd.ms_tick && elapsed_ms != 8'hFF) begin
        elapsed_ms <= elapsed_ms + 8'd1;
      end
    end
  end

  always_comb begin
    cur_byte = 8'd0;
    if (byte_index < 4'(ssw_pkg::CHARS)) begin
      cur_byte = rd_data[byte_index];
    end
  end

  assign slot_off = 16'({active_slot, 4'b0000});

  always_comb begin
    stat.op         = op;
    stat.hit        = (op == ssw_pkg::OP_ADD) ? (rd_data[0] == 8'd0) : (rd_data == txt);
    stat.chk_last   = (chk_addr == LAST);
    stat.scan_last  = (scan_addr == LAST);
    stat.elapsed_ge = (elapsed_ms >= write_cycle_ms);
    stat.bus_flag   = bus_flag;
    stat.is_delete  = is_delete;
    stat.byte_done  = (byte_index >= 4'(ssw_pkg::CHARS));
    stat.byte_zero  = (cur_byte == 8'd0);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      write_valid   <= cmd.out_wv;
      write_address <= cmd.out_wv ?
                       (table_base_address + slot_off + {12'd0, byte_index}) : 16'd0;
      write_data    <= cmd.out_wv ? cur_byte : 8'd0;
      busy_res      <= cmd.out_busy;
      status        <= cmd.out_st;
      slot          <= (cmd.out_st == ssw_pkg::ST_STARTED || cmd.out_st == ssw_pkg::ST_DROPPED)
                       ? 8'(chk_addr) : 8'd0;
    end
  end

endmodule

### hdl/ssw_ctrl.sv
// Controller: item sequencing, table scan, clearing pass and write-back state machine.
module ssw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          in_op,
  output logic                in_ready,
  input  ssw_pkg::ctrl_stat_t stat,
  output ssw_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_SCAN_FIRST = 3'd2;
  localparam logic [2:0] S_SCAN       = 3'd3;
  localparam logic [2:0] S_FINISH     = 3'd4;

  localparam logic [1:0] SEQ_IDLE       = 2'd0;
  localparam logic [1:0] SEQ_ISSUE      = 2'd1;
  localparam logic [1:0] SEQ_WAIT_BUS   = 2'd2;
  localparam logic [1:0] SEQ_WAIT_CYCLE = 2'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] seq;
  logic [1:0] seq_next;
  logic       found;
  logic       found_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    seq_next   = seq;
    found_next = found;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.scan_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          found_next = 1'b0;
          if (in_op == ssw_pkg::OP_ADD || in_op == ssw_pkg::OP_DELETE) begin
            cmd.scan_rst = 1'b1;
            state_next   = S_SCAN_FIRST;
          end else begin
            if (in_op == ssw_pkg::OP_UPDATE &&
                (seq == SEQ_ISSUE || (seq == SEQ_WAIT_CYCLE && stat.elapsed_ge))) begin
              cmd.rd_active = 1'b1;
            end
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN_FIRST: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.hit_wr = 1'b1;
          found_next = 1'b1;
          state_next = S_FINISH;
        end else if (stat.chk_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          case (stat.op)
            ssw_pkg::OP_UPDATE: begin
              case (seq)
                SEQ_ISSUE: begin
                  cmd.out_wv  = 1'b1;
                  cmd.bus_clr = 1'b1;
                  seq_next    = SEQ_WAIT_BUS;
                end
                SEQ_WAIT_BUS: begin
                  if (stat.bus_flag) begin
                    cmd.ms_clr = 1'b1;
                    seq_next   = SEQ_WAIT_CYCLE;
                  end
                end
                SEQ_WAIT_CYCLE: begin
                  if (stat.elapsed_ge) begin
                    if (stat.is_delete || stat.byte_done || stat.byte_zero) begin
                      seq_next = SEQ_IDLE;
                    end else begin
                      cmd.byte_inc = 1'b1;
                      seq_next     = SEQ_ISSUE;
                    end
                  end
                end
                default: ;
              endcase
            end
            ssw_pkg::OP_TICK:     cmd.ms_tick = 1'b1;
            ssw_pkg::OP_BUS_DONE: cmd.bus_set = 1'b1;
            ssw_pkg::OP_ADD, ssw_pkg::OP_DELETE: begin
              if (!found) begin
                cmd.out_st = ssw_pkg::ST_NOT_FOUND;
              end else if (seq == SEQ_IDLE) begin
                cmd.start_wb = 1'b1;
                cmd.out_st   = ssw_pkg::ST_STARTED;
                seq_next     = SEQ_ISSUE;
              end else begin
                cmd.out_st = ssw_pkg::ST_DROPPED;
              end
            end
            default: ;
          endcase
          cmd.out_busy = (seq_next != SEQ_IDLE);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      seq   <= SEQ_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
      found <= found_next;
    end
  end

endmodule
